// ===== design/fcrc_pkg.sv =====
// Shared types, status codes and CRC-16 helpers for the FIT chunk checker.
// Used by every module of the block; no other dependencies.
`timescale 1ns / 1ps

package fcrc_pkg;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_EMPTY    = 3'd1,
      ST_HLEN     = 3'd2,
      ST_SHORTHDR = 3'd3,
      ST_HCRC     = 3'd4,
      ST_SIG      = 3'd5,
      ST_SHORTPAY = 3'd6,
      ST_PCRC     = 3'd7
   } status_type;

   typedef enum logic [5:0] {
      PH_FIRST   = 6'b000001,
      PH_NEXT    = 6'b000010,
      PH_HEADER  = 6'b000100,
      PH_PAYLOAD = 6'b001000,
      PH_TRAILER = 6'b010000,
      PH_STOPPED = 6'b100000
   } phase_type;

   typedef enum logic {
      KIND_BYTE   = 1'b0,
      KIND_STATUS = 1'b1
   } kind_type;

   localparam logic [3:0] HLEN_SHORT = 4'd12;
   localparam logic [3:0] HLEN_LONG  = 4'd14;
   localparam int TDATA_OUT_W = 72;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       end_of_data;
   } item_type;

   typedef struct packed {
      kind_type   result_kind;
      logic [7:0] payload_byte;
      status_type chunk_status;
      logic [7:0] protocol_version;
      logic [15:0] profile_version;
      logic [31:0] payload_length;
   } result_type;

   function automatic logic [15:0] crc_tab(input logic [3:0] idx);
      logic [15:0] v;
      case (idx)
         4'h0: v = 16'h0000;
         4'h1: v = 16'hCC01;
         4'h2: v = 16'hD801;
         4'h3: v = 16'h1400;
         4'h4: v = 16'hF001;
         4'h5: v = 16'h3C00;
         4'h6: v = 16'h2800;
         4'h7: v = 16'hE401;
         4'h8: v = 16'hA001;
         4'h9: v = 16'h6C00;
         4'hA: v = 16'h7800;
         4'hB: v = 16'hB401;
         4'hC: v = 16'h5000;
         4'hD: v = 16'h9C01;
         4'hE: v = 16'h8801;
         default: v = 16'h4400;
      endcase
      return v;
   endfunction

   function automatic logic [15:0] crc_nibble(input logic [15:0] c, input logic [3:0] nib);
      logic [15:0] t;
      t = crc_tab(c[3:0]);
      return ({4'h0, c[15:4]} & 16'h0FFF) ^ t ^ crc_tab(nib);
   endfunction

   function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
      return crc_nibble(crc_nibble(c, b[3:0]), b[7:4]);
   endfunction

   function automatic logic [7:0] sig_char(input logic [1:0] idx);
      logic [7:0] v;
      case (idx)
         2'd0: v = 8'h2E;
         2'd1: v = 8'h46;
         2'd2: v = 8'h49;
         default: v = 8'h54;
      endcase
      return v;
   endfunction

endpackage

// ===== design/fcrc_in_stage.sv =====
// Input register of the FIT chunk checker: holds one word from the slave side.
// Depends on fcrc_pkg.
`timescale 1ns / 1ps

module fcrc_in_stage
   import fcrc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   output logic     item_valid,
   output item_type item,
   input  logic     item_take
);

   logic     valid_ff, valid_in;
   item_type item_ff;

   assign in_ready   = !valid_ff || item_take;
   assign valid_in   = in_ready ? in_valid : valid_ff;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         item_ff <= in_item;
      end
   end

endmodule

// ===== design/fcrc_check.sv =====
// Chunk parser: header capture, signature and CRC-16 checks, one word per cycle
// while the result slot is free. Depends on fcrc_pkg.
`timescale 1ns / 1ps

module fcrc_check
   import fcrc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       item_valid,
   input  item_type   item,
   input  logic       slot_free,
   output logic       item_take,
   output logic       res_push,
   output result_type res
);

   phase_type   phase_ff, phase_in;
   logic [31:0] count_ff, count_in;
   logic        hlen14_ff, hlen14_in;
   logic [15:0] crc_ff, crc_in;
   logic [31:0] plen_ff, plen_in;
   logic [7:0]  proto_ff, proto_in;
   logic [15:0] prof_ff, prof_in;
   logic        sig_ok_ff, sig_ok_in;
   logic        crc_nz_ff, crc_nz_in;

   logic        emit;
   kind_type    kind;
   status_type  status;
   logic [7:0]  pbyte;
   logic [7:0]  b;
   logic [15:0] crc_upd;
   logic [31:0] count_inc;
   logic [3:0]  hidx;
   logic        advance;

   assign item_take = slot_free;
   assign advance   = item_valid && slot_free;
   assign b         = item.data_byte;
   assign crc_upd   = crc_byte(crc_ff, b);
   assign count_inc = count_ff + 32'd1;
   assign hidx      = count_ff[3:0];

   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      hlen14_in = hlen14_ff;
      crc_in    = crc_ff;
      plen_in   = plen_ff;
      proto_in  = proto_ff;
      prof_in   = prof_ff;
      sig_ok_in = sig_ok_ff;
      crc_nz_in = crc_nz_ff;
      emit      = 1'b0;
      kind      = KIND_STATUS;
      status    = ST_OK;
      pbyte     = 8'h00;
      if (phase_ff == PH_STOPPED) begin
         emit = 1'b0;
      end else if (!item.byte_valid) begin
         if (item.end_of_data) begin
            case (phase_ff)
               PH_FIRST: begin
                  emit = 1'b1; status = ST_EMPTY; phase_in = PH_STOPPED;
               end
               PH_NEXT: begin
                  phase_in = PH_FIRST;
               end
               PH_HEADER: begin
                  emit = 1'b1; status = ST_SHORTHDR; phase_in = PH_STOPPED;
               end
               default: begin
                  emit = 1'b1; status = ST_SHORTPAY; phase_in = PH_STOPPED;
               end
            endcase
         end
      end else if (phase_ff == PH_FIRST || phase_ff == PH_NEXT) begin
         proto_in  = 8'h00;
         prof_in   = 16'h0000;
         plen_in   = 32'h0;
         sig_ok_in = 1'b1;
         crc_nz_in = 1'b0;
         crc_in    = crc_byte(16'h0000, b);
         if (b != {4'h0, HLEN_SHORT} && b != {4'h0, HLEN_LONG}) begin
            emit = 1'b1; status = ST_HLEN; phase_in = PH_STOPPED;
         end else begin
            hlen14_in = (b == {4'h0, HLEN_LONG});
            count_in  = 32'd1;
            phase_in  = PH_HEADER;
            if (item.end_of_data) begin
               emit = 1'b1; status = ST_SHORTHDR; phase_in = PH_STOPPED;
            end
         end
      end else begin
         crc_in = crc_upd;
         case (phase_ff)
            PH_HEADER: begin
               case (hidx)
                  4'd1: proto_in = b;
                  4'd2: prof_in[7:0] = b;
                  4'd3: prof_in[15:8] = b;
                  4'd4: plen_in[7:0] = b;
                  4'd5: plen_in[15:8] = b;
                  4'd6: plen_in[23:16] = b;
                  4'd7: plen_in[31:24] = b;
                  4'd8, 4'd9, 4'd10, 4'd11: begin
                     if (b != sig_char(hidx[1:0])) sig_ok_in = 1'b0;
                  end
                  default: begin
                     if (b != 8'h00) crc_nz_in = 1'b1;
                  end
               endcase
               count_in = count_inc;
               if (count_inc[3:0] < (hlen14_ff ? HLEN_LONG : HLEN_SHORT)) begin
                  if (item.end_of_data) begin
                     emit = 1'b1; status = ST_SHORTHDR; phase_in = PH_STOPPED;
                  end
               end else if (hlen14_ff && crc_nz_in && crc_upd != 16'h0000) begin
                  emit = 1'b1; status = ST_HCRC; phase_in = PH_STOPPED;
               end else if (!sig_ok_in) begin
                  emit = 1'b1; status = ST_SIG; phase_in = PH_STOPPED;
               end else if (item.end_of_data) begin
                  emit = 1'b1; status = ST_SHORTPAY; phase_in = PH_STOPPED;
               end else begin
                  count_in  = 32'h0;
                  crc_nz_in = 1'b0;
                  phase_in  = (plen_in == 32'h0) ? PH_TRAILER : PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               if (item.end_of_data) begin
                  emit = 1'b1; status = ST_SHORTPAY; phase_in = PH_STOPPED;
               end else begin
                  count_in = count_inc;
                  if (count_inc >= plen_ff) begin
                     count_in = 32'h0;
                     phase_in = PH_TRAILER;
                  end
                  emit  = 1'b1;
                  kind  = KIND_BYTE;
                  pbyte = b;
               end
            end
            default: begin
               if (b != 8'h00) crc_nz_in = 1'b1;
               if (count_ff == 32'h0) begin
                  count_in = 32'd1;
                  if (item.end_of_data) begin
                     emit = 1'b1; status = ST_SHORTPAY; phase_in = PH_STOPPED;
                  end
               end else if (crc_nz_in && crc_upd != 16'h0000) begin
                  emit = 1'b1; status = ST_PCRC; phase_in = PH_STOPPED;
               end else begin
                  count_in = 32'h0;
                  phase_in = item.end_of_data ? PH_FIRST : PH_NEXT;
                  emit     = 1'b1;
               end
            end
         endcase
      end
   end

   assign res_push = advance && emit;
   assign res = '{result_kind: kind, payload_byte: pbyte, chunk_status: status,
                  protocol_version: proto_in, profile_version: prof_in,
                  payload_length: plen_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_FIRST;
         count_ff  <= 32'h0;
         hlen14_ff <= 1'b0;
         crc_ff    <= 16'h0000;
         plen_ff   <= 32'h0;
         proto_ff  <= 8'h00;
         prof_ff   <= 16'h0000;
         sig_ok_ff <= 1'b1;
         crc_nz_ff <= 1'b0;
      end else if (advance) begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         hlen14_ff <= hlen14_in;
         crc_ff    <= crc_in;
         plen_ff   <= plen_in;
         proto_ff  <= proto_in;
         prof_ff   <= prof_in;
         sig_ok_ff <= sig_ok_in;
         crc_nz_ff <= crc_nz_in;
      end
   end

endmodule

// ===== design/fcrc_out_stage.sv =====
// Result register of the FIT chunk checker: holds one word for the master side.
// Depends on fcrc_pkg.
`timescale 1ns / 1ps

module fcrc_out_stage
   import fcrc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       res_push,
   input  result_type res,
   output logic       slot_free,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_res
);

   logic       valid_ff, valid_in;
   result_type res_ff;

   assign slot_free = !valid_ff || out_ready;
   assign valid_in  = slot_free ? res_push : valid_ff;
   assign out_valid = valid_ff;
   assign out_res   = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (slot_free && res_push) begin
         res_ff <= res;
      end
   end

endmodule

// ===== design/fit_chunk_header_crc_checker_top.sv =====
// FIT chunk header and CRC-16 checker, top level.
// Word path: fcrc_in_stage register, fcrc_check logic, fcrc_out_stage register.
// Throughput: one word per cycle unless stalled; fcrc_check updates state once per word.
// Reset: synchronous, active high; clears valids and returns to the first chunk start.
// Depends on fcrc_pkg, fcrc_in_stage, fcrc_check and fcrc_out_stage.
`timescale 1ns / 1ps

module fit_chunk_header_crc_checker_top
   import fcrc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,  // [7:0] data_byte
   input  logic                   req_tuser,  // byte_valid
   input  logic                   req_tlast,  // end_of_data
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [7:0] payload_byte, [10:8] chunk_status, [18:11] protocol_version,
   // [34:19] profile_version, [66:35] payload_length, [71:67] zero
   output logic [TDATA_OUT_W-1:0] rsp_tdata,
   output logic                   rsp_tuser   // result_kind
);

   item_type   in_item, item;
   logic       item_valid, item_take, slot_free, res_push;
   result_type res, out_res;

   assign in_item = '{data_byte: req_tdata, byte_valid: req_tuser, end_of_data: req_tlast};

   fcrc_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_item    (in_item),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take)
   );

   fcrc_check u_check (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .slot_free  (slot_free),
      .item_take  (item_take),
      .res_push   (res_push),
      .res        (res)
   );

   fcrc_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .res_push  (res_push),
      .res       (res),
      .slot_free (slot_free),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_res   (out_res)
   );

   assign rsp_tuser = out_res.result_kind;
   assign rsp_tdata = {5'b00000, out_res.payload_length, out_res.profile_version,
                       out_res.protocol_version, out_res.chunk_status, out_res.payload_byte};

endmodule

// ===== bench/fit_chunk_header_crc_checker_top_tb.sv =====
// Self-checking bench for the FIT chunk header and CRC-16 checker: builds chunks with
// real CRCs, drives them with bursty gaps against a stalling sink and scores every word.
// Depends on fcrc_pkg and fit_chunk_header_crc_checker_top.
`timescale 1ns / 1ps

module fit_chunk_header_crc_checker_top_tb;
   import fcrc_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_WORDS = 400;

   typedef enum {FINISH_OPEN, FINISH_ON_BYTE, FINISH_MARKER} finish_type;
   typedef enum {RX_OPEN, RX_COIN, RX_EVERY_FOURTH, RX_RARE} stall_mode_type;

   class fit_chunk_tracker;
      localparam logic [31:0] FIT_TAG = ".FIT";

      result_type  due[$];
      int unsigned faults = 0;
      phase_type   phase = PH_FIRST;
      logic [31:0] count = '0;
      logic [31:0] pay_len = '0;
      logic [3:0]  hdr_len = '0;
      logic [15:0] crc = '0;
      logic [7:0]  proto = '0;
      logic [15:0] profile = '0;
      bit          sig_ok = 1'b1;
      bit          crc_set = 1'b0;

      static function logic [15:0] fold_byte(logic [15:0] c, logic [7:0] b);
         c = c ^ {8'h00, b};
         for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
         return c;
      endfunction

      function void push_result(kind_type k, logic [7:0] b, status_type st);
         result_type r;
         r.result_kind      = k;
         r.payload_byte     = b;
         r.chunk_status     = st;
         r.protocol_version = proto;
         r.profile_version  = profile;
         r.payload_length   = pay_len;
         due.insert(due.size(), r);
      endfunction

      function void stop_with(status_type st);
         phase = PH_STOPPED;
         push_result(KIND_STATUS, 8'h00, st);
      endfunction

      function void take_word(item_type w);
         logic [7:0] b;
         bit         last;
         b    = w.data_byte;
         last = w.end_of_data;
         if (phase == PH_STOPPED) return;
         if (!w.byte_valid) begin
            if (!last) return;
            case (phase)
               PH_FIRST:  stop_with(ST_EMPTY);
               PH_NEXT:   phase = PH_FIRST;
               PH_HEADER: stop_with(ST_SHORTHDR);
               default:   stop_with(ST_SHORTPAY);
            endcase
            return;
         end
         if (phase == PH_FIRST || phase == PH_NEXT) begin
            proto   = '0;
            profile = '0;
            pay_len = '0;
            sig_ok  = 1'b1;
            crc_set = 1'b0;
            crc     = fold_byte(16'h0000, b);
            if (b != HLEN_SHORT && b != HLEN_LONG) begin
               stop_with(ST_HLEN);
            end else begin
               hdr_len = b[3:0];
               count   = 1;
               phase   = PH_HEADER;
               if (last) stop_with(ST_SHORTHDR);
            end
            return;
         end
         crc = fold_byte(crc, b);
         case (phase)
            PH_HEADER: begin
               if (count == 1) proto = b;
               else if (count <= 3) profile[8*(count-2) +: 8] = b;
               else if (count <= 7) pay_len[8*(count-4) +: 8] = b;
               else if (count <= 11) begin
                  if (b != FIT_TAG[8*(11-count) +: 8]) sig_ok = 1'b0;
               end else if (b != 8'h00) crc_set = 1'b1;
               count++;
               if (count < hdr_len) begin
                  if (last) stop_with(ST_SHORTHDR);
               end else if (hdr_len == HLEN_LONG && crc_set && crc != 16'h0000) begin
                  stop_with(ST_HCRC);
               end else if (!sig_ok) begin
                  stop_with(ST_SIG);
               end else if (last) begin
                  stop_with(ST_SHORTPAY);
               end else begin
                  count   = 0;
                  crc_set = 1'b0;
                  phase   = (pay_len == 0) ? PH_TRAILER : PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               if (last) begin
                  stop_with(ST_SHORTPAY);
               end else begin
                  count++;
                  if (count >= pay_len) begin
                     count = 0;
                     phase = PH_TRAILER;
                  end
                  push_result(KIND_BYTE, b, ST_OK);
               end
            end
            default: begin
               if (b != 8'h00) crc_set = 1'b1;
               if (count == 0) begin
                  count = 1;
                  if (last) stop_with(ST_SHORTPAY);
               end else if (crc_set && crc != 16'h0000) begin
                  stop_with(ST_PCRC);
               end else begin
                  count = 0;
                  phase = last ? PH_FIRST : PH_NEXT;
                  push_result(KIND_STATUS, 8'h00, ST_OK);
               end
            end
         endcase
      endfunction

      function void match_word(result_type got);
         result_type want;
         if (due.size() == 0) begin
            $error("result word with nothing expected: %h", got);
            faults++;
            return;
         end
         want = due.pop_front();
         if (got.result_kind !== want.result_kind) begin
            $error("result_kind: expected %0d, got %0d", want.result_kind, got.result_kind);
            faults++;
         end
         if (got.payload_byte !== want.payload_byte) begin
            $error("payload_byte: expected %0d, got %0d", want.payload_byte, got.payload_byte);
            faults++;
         end
         if (got.chunk_status !== want.chunk_status) begin
            $error("chunk_status: expected %0d, got %0d", want.chunk_status, got.chunk_status);
            faults++;
         end
         if (got.protocol_version !== want.protocol_version) begin
            $error("protocol_version: expected %0d, got %0d",
                   want.protocol_version, got.protocol_version);
            faults++;
         end
         if (got.profile_version !== want.profile_version) begin
            $error("profile_version: expected %0d, got %0d",
                   want.profile_version, got.profile_version);
            faults++;
         end
         if (got.payload_length !== want.payload_length) begin
            $error("payload_length: expected %0d, got %0d",
                   want.payload_length, got.payload_length);
            faults++;
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [7:0]             req_tdata;
   logic                   req_tuser;
   logic                   req_tlast;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [TDATA_OUT_W-1:0] rsp_tdata;
   logic                   rsp_tuser;

   fit_chunk_tracker tracker = new();
   logic [7:0]       chunk_bytes[$];
   int               burst_left = 0;
   int               words_sent = 0;
   int               cycle_count = 0;
   bit               rsp_hold_request = 1'b0;

   fit_chunk_header_crc_checker_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   always @(posedge clock) begin : rsp_monitor
      result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.result_kind      = kind_type'(rsp_tuser);
         got.payload_byte     = rsp_tdata[7:0];
         got.chunk_status     = status_type'(rsp_tdata[10:8]);
         got.protocol_version = rsp_tdata[18:11];
         got.profile_version  = rsp_tdata[34:19];
         got.payload_length   = rsp_tdata[66:35];
         tracker.match_word(got);
      end
   end

   initial begin : rsp_side
      int             hold_left;
      int             tick;
      stall_mode_type mode;
      hold_left  = 0;
      tick       = 0;
      mode       = RX_OPEN;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_request) begin
            rsp_hold_request = 1'b0;
            hold_left = 300;
         end
         if (tick % 40 == 0) mode = stall_mode_type'($urandom_range(0, 3));
         tick++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready = 1'b0;
         end else begin
            case (mode)
               RX_OPEN:         rsp_tready = 1'b1;
               RX_COIN:         rsp_tready = 1'($urandom_range(0, 1));
               RX_EVERY_FOURTH: rsp_tready = (tick % 4 != 0);
               RX_RARE:         rsp_tready = ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   // Enter and leave at a falling edge.
   task automatic put_word(input logic [7:0] data, input bit valid, input bit last);
      item_type w;
      int       gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 7);
         if (gap != 0) begin
            req_tvalid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      req_tdata  = data;
      req_tuser  = valid;
      req_tlast  = last;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      w.data_byte   = data;
      w.byte_valid  = valid;
      w.end_of_data = last;
      tracker.take_word(w);
      words_sent++;
      burst_left--;
      @(negedge clock);
   endtask

   task automatic send_bytes(input int n, input finish_type fin);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 11) == 0) put_word(8'($urandom), 1'b0, 1'b0);
         put_word(chunk_bytes[i], 1'b1, fin == FINISH_ON_BYTE && i == n - 1);
      end
      if (fin == FINISH_MARKER) put_word(8'($urandom), 1'b0, 1'b1);
   endtask

   function automatic void append_byte(input logic [7:0] v);
      chunk_bytes.insert(chunk_bytes.size(), v);
   endfunction

   function automatic void append_crc(input bit on);
      logic [15:0] c = 16'h0000;
      foreach (chunk_bytes[i]) c = fit_chunk_tracker::fold_byte(c, chunk_bytes[i]);
      append_byte(on ? c[7:0] : 8'h00);
      append_byte(on ? c[15:8] : 8'h00);
   endfunction

   function automatic void build_chunk(input logic [3:0] hlen, input logic [31:0] len_field,
                                       input int body, input bit hcrc_on, input bit tcrc_on,
                                       input logic [31:0] tag_flip);
      logic [31:0] tag;
      tag = fit_chunk_tracker::FIT_TAG ^ tag_flip;
      chunk_bytes.delete();
      append_byte({4'h0, hlen});
      repeat (3) append_byte(8'($urandom));
      for (int i = 0; i < 4; i++) append_byte(len_field[8*i +: 8]);
      for (int i = 0; i < 4; i++) append_byte(tag[8*(3-i) +: 8]);
      if (hlen == HLEN_LONG) append_crc(hcrc_on);
      for (int i = 0; i < body; i++) begin
         case ($urandom_range(0, 7))
            0:       append_byte(8'h00);
            1:       append_byte(8'hFF);
            default: append_byte(8'($urandom));
         endcase
      end
      append_crc(tcrc_on);
   endfunction

   // Keep at least one byte of the pair nonzero so the check cannot be skipped.
   function automatic void spoil_crc(input int at);
      logic [7:0] m;
      m = 8'($urandom_range(1, 255));
      chunk_bytes[at] ^= m;
      if (chunk_bytes[at] == 8'h00 && chunk_bytes[at+1] == 8'h00) chunk_bytes[at+1] = 8'h01;
   endfunction

   task automatic send_good_chunk(input int body, input finish_type fin);
      logic [3:0] hlen;
      hlen = $urandom_range(0, 1) ? HLEN_LONG : HLEN_SHORT;
      build_chunk(hlen, body, body, $urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0, '0);
      send_bytes(chunk_bytes.size(), fin);
   endtask

   task automatic send_fault();
      status_type pick;
      logic [3:0] hlen;
      logic [7:0] b;
      finish_type fin;
      int         n;
      pick = status_type'($urandom_range(1, 7));
      hlen = $urandom_range(0, 1) ? HLEN_LONG : HLEN_SHORT;
      fin  = $urandom_range(0, 1) ? FINISH_ON_BYTE : FINISH_MARKER;
      n    = $urandom_range(0, 12);
      case (pick)
         ST_EMPTY: begin
            send_good_chunk(n, FINISH_ON_BYTE);
            put_word(8'($urandom), 1'b0, 1'b1);
         end
         ST_HLEN: begin
            do b = 8'($urandom); while (b == HLEN_SHORT || b == HLEN_LONG);
            put_word(b, 1'b1, 1'($urandom_range(0, 1)));
         end
         ST_SHORTHDR: begin
            build_chunk(hlen, n, n, 1'b1, 1'b1, '0);
            send_bytes($urandom_range(1, hlen - 1), fin);
         end
         ST_HCRC: begin
            build_chunk(HLEN_LONG, n, n, 1'b1, 1'b1, '0);
            spoil_crc(12);
            send_bytes(chunk_bytes.size(), FINISH_OPEN);
         end
         ST_SIG: begin
            build_chunk(hlen, n, n, 1'b1, 1'b1,
                        32'($urandom_range(1, 255)) << (8 * $urandom_range(0, 3)));
            send_bytes(hlen, FINISH_OPEN);
         end
         ST_SHORTPAY: begin
            build_chunk(hlen, $urandom_range(0, 1) ? $urandom : n, n, 1'b1, 1'b1, '0);
            send_bytes($urandom_range(hlen, chunk_bytes.size() - 1), fin);
         end
         ST_PCRC: begin
            build_chunk(hlen, n, n, 1'b1, 1'b1, '0);
            spoil_crc(chunk_bytes.size() - 2);
            send_bytes(chunk_bytes.size(), finish_type'($urandom_range(0, 2)));
         end
      endcase
   endtask

   task automatic await_reports();
      while (tracker.due.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin : stimulus
      bit         paused;
      int         body;
      finish_type fin;
      paused     = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      req_tlast  = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // short header, empty payload, unchecked trailer, then end on the chunk boundary
      build_chunk(HLEN_SHORT, 0, 0, 1'b0, 1'b0, '0);
      send_bytes(chunk_bytes.size(), FINISH_OPEN);
      put_word(8'hFF, 1'b0, 1'b1);
      // long header with a checked CRC, end flagged on the last CRC byte
      build_chunk(HLEN_LONG, 2, 2, 1'b1, 1'b1, 32'h0);
      send_bytes(chunk_bytes.size(), FINISH_ON_BYTE);

      // hold the sink off while a long payload backs up into the input
      rsp_hold_request = 1'b1;
      send_good_chunk(100, FINISH_OPEN);

      while (words_sent < RANDOM_WORDS) begin
         if (!paused && words_sent > RANDOM_WORDS / 2) begin
            paused     = 1'b1;
            req_tvalid = 1'b0;
            await_reports();
         end
         body = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120) : $urandom_range(0, 24);
         case ($urandom_range(0, 5))
            0:       fin = FINISH_ON_BYTE;
            1:       fin = FINISH_MARKER;
            default: fin = FINISH_OPEN;
         endcase
         send_good_chunk(body, fin);
      end

      send_fault();
      // block is stopped now: these words must be dropped
      repeat (20) put_word(8'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      req_tvalid = 1'b0;

      await_reports();
      repeat (20) @(posedge clock);
      if (tracker.faults == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule
